FILE: design/nfc_rfp_pkg.sv
// Shared types and constants of the NFC response frame parser.
`timescale 1ns / 1ps
`default_nettype none

package nfc_rfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 8;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COMMAND = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY  = 8'd1;

    localparam logic [BYTE_W-1:0] EXPECTED_COMMAND_RST = 8'h00;
    localparam logic [BYTE_W-1:0] BUFFER_CAPACITY_RST  = 8'hFF;

    // Header bytes
    localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] START1_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] START2_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] TFI_IN        = 8'hD5;

    typedef struct packed {
        logic                payload_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic [BYTE_W-1:0]   payload_index;
        logic                frame_done;
        logic [STATUS_W-1:0] frame_status;
        logic [BYTE_W-1:0]   payload_length;
    } t_result;

endpackage

`default_nettype wire

FILE: design/nfc_response_frame_parser_top.sv
// Top level of the NFC response frame parser: channels, config registers, pipeline.
// A byte accepted into the input register passes through the core into the result
// register, which drives the output ports; one result item per input byte.
// Throughput: one byte per cycle unless i_out_ready stalls; the input and result
// registers let a new byte enter while a finished result waits for i_out_ready.
// Reset: synchronous, active low on i_rst_n; clears the parser state, the channel
// valid flags and the registers (expected_command 0, buffer_capacity 255).
`timescale 1ns / 1ps
`default_nettype none

module nfc_response_frame_parser_top
    import nfc_rfp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    // input byte channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_frame_start,
    input  wire logic [BYTE_W-1:0]    i_wire_byte,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_payload_valid,
    output logic [BYTE_W-1:0]         o_payload_byte,
    output logic [BYTE_W-1:0]         o_payload_index,
    output logic                      o_frame_done,
    output logic [STATUS_W-1:0]       o_frame_status,
    output logic [BYTE_W-1:0]         o_payload_length
);

    logic [BYTE_W-1:0] r_expected_command;
    logic [BYTE_W-1:0] r_buffer_capacity;

    logic              r_in_valid;
    logic              r_in_start;
    logic [BYTE_W-1:0] r_in_byte;

    logic              r_out_valid;
    t_result           r_out;
    t_result           core_res;
    logic              adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_command <= EXPECTED_COMMAND_RST;
            r_buffer_capacity  <= BUFFER_CAPACITY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_EXPECTED_COMMAND: r_expected_command <= i_cfg_data;
                REG_BUFFER_CAPACITY:  r_buffer_capacity  <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Advance the held byte into the result register when that is free
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_start <= i_frame_start;
            r_in_byte  <= i_wire_byte;
        end
    end

    nfc_rfp_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_adv              (adv),
        .i_start            (r_in_start),
        .i_byte             (r_in_byte),
        .i_expected_command (r_expected_command),
        .i_buffer_capacity  (r_buffer_capacity),
        .o_res              (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_valid  = r_out.payload_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_index  = r_out.payload_index;
    assign o_frame_done     = r_out.frame_done;
    assign o_frame_status   = r_out.frame_status;
    assign o_payload_length = r_out.payload_length;

`ifndef SYNTHESIS
    a_free_out_takes_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled while result register is empty");
    a_byte_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_payload_valid && o_frame_done))
        else $error("payload byte and frame outcome in one item");
    a_len_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_payload_length != 8'd0) |->
            (o_frame_done && o_frame_status == ST_OK))
        else $error("payload length reported without ok status");
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_status == ST_OK || o_frame_status == ST_BAD ||
                         o_frame_status == ST_NOSP))
        else $error("illegal frame status code");
`endif

endmodule

`default_nettype wire

FILE: design/nfc_rfp_core.sv
// Frame parsing state machine: per-byte checks, payload sum and result build.
`timescale 1ns / 1ps
`default_nettype none

module nfc_rfp_core
    import nfc_rfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic              i_start,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [BYTE_W-1:0] i_expected_command,
    input  wire logic [BYTE_W-1:0] i_buffer_capacity,
    output t_result                o_res
);

    typedef enum logic [3:0] {
        PH_PRE  = 4'd0,
        PH_SC1  = 4'd1,
        PH_SC2  = 4'd2,
        PH_LEN  = 4'd3,
        PH_LCS  = 4'd4,
        PH_TFI  = 4'd5,
        PH_CMD  = 4'd6,
        PH_DATA = 4'd7,
        PH_DCS  = 4'd8,
        PH_POST = 4'd9,
        PH_IDLE = 4'd10
    } t_phase;

    t_phase            r_phase, n_phase, cur_phase;
    logic [BYTE_W-1:0] r_frame_length, n_frame_length, cur_frame_length;
    logic [BYTE_W-1:0] r_byte_count, n_byte_count, cur_byte_count;
    logic [BYTE_W-1:0] r_running_sum, n_running_sum, cur_running_sum;
    logic              r_overflow, n_overflow, cur_overflow;

    logic [BYTE_W-1:0] flipped;
    logic [BYTE_W-1:0] cmd_code;
    logic [BYTE_W-1:0] len_minus2;
    logic [BYTE_W-1:0] count_inc;
    logic              done;
    t_result           res;

    // SPI bytes arrive LSB first: mirror the bit order
    always_comb begin
        for (int k = 0; k < BYTE_W; k++) begin
            flipped[k] = i_byte[BYTE_W-1-k];
        end
    end

    assign cmd_code   = i_expected_command + 8'd1;
    assign len_minus2 = cur_frame_length - 8'd2;
    assign count_inc  = cur_byte_count + 8'd1;

    always_comb begin
        // frame_start restarts the parser before the byte is used
        if (i_start) begin
            cur_phase        = PH_PRE;
            cur_frame_length = '0;
            cur_byte_count   = '0;
            cur_running_sum  = '0;
            cur_overflow     = 1'b0;
        end else begin
            cur_phase        = r_phase;
            cur_frame_length = r_frame_length;
            cur_byte_count   = r_byte_count;
            cur_running_sum  = r_running_sum;
            cur_overflow     = r_overflow;
        end

        n_phase        = cur_phase;
        n_frame_length = cur_frame_length;
        n_byte_count   = cur_byte_count;
        n_running_sum  = cur_running_sum;
        n_overflow     = cur_overflow;
        res            = '0;
        done           = 1'b0;

        case (cur_phase)
            PH_PRE: begin
                if (flipped == PREAMBLE_BYTE) n_phase = PH_SC1;
                else done = 1'b1;
            end
            PH_SC1: begin
                if (flipped == START1_BYTE) n_phase = PH_SC2;
                else done = 1'b1;
            end
            PH_SC2: begin
                if (flipped == START2_BYTE) n_phase = PH_LEN;
                else done = 1'b1;
            end
            PH_LEN: begin
                n_frame_length = flipped;
                n_phase        = PH_LCS;
            end
            PH_LCS: begin
                if (cur_frame_length + flipped == 8'd0) n_phase = PH_TFI;
                else done = 1'b1;
            end
            PH_TFI: begin
                if (flipped == TFI_IN) n_phase = PH_CMD;
                else done = 1'b1;
            end
            PH_CMD: begin
                if (flipped != cmd_code) begin
                    done = 1'b1;
                end else begin
                    n_frame_length = len_minus2;
                    n_overflow     = (len_minus2 > i_buffer_capacity);
                    n_running_sum  = TFI_IN + cmd_code;
                    n_byte_count   = '0;
                    n_phase        = (len_minus2 == 8'd0) ? PH_DCS : PH_DATA;
                end
            end
            PH_DATA: begin
                // oversized payload: consume without emitting
                if (!cur_overflow) begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = flipped;
                    res.payload_index = cur_byte_count;
                    n_running_sum     = cur_running_sum + flipped;
                end
                n_byte_count = count_inc;
                if (count_inc == cur_frame_length) n_phase = PH_DCS;
            end
            PH_DCS: begin
                if (cur_overflow || (cur_running_sum + flipped == 8'd0)) begin
                    n_phase = PH_POST;
                end else begin
                    done = 1'b1;
                end
            end
            PH_POST: begin
                done = 1'b1;
                if (cur_overflow) begin
                    res.frame_status = ST_NOSP;
                end else begin
                    res.frame_status   = ST_OK;
                    res.payload_length = cur_frame_length;
                end
            end
            default: begin
                // ignore bytes until the next frame_start
            end
        endcase

        if (done) begin
            res.frame_done = 1'b1;
            if (cur_phase != PH_POST) res.frame_status = ST_BAD;
            n_phase = PH_IDLE;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_PRE;
            r_frame_length <= '0;
            r_byte_count   <= '0;
            r_running_sum  <= '0;
            r_overflow     <= 1'b0;
        end else if (i_adv) begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_byte_count   <= n_byte_count;
            r_running_sum  <= n_running_sum;
            r_overflow     <= n_overflow;
        end
    end

`ifndef SYNTHESIS
    a_ovf_only_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_start && r_overflow && r_phase == PH_DATA) |-> !o_res.payload_valid)
        else $error("payload byte emitted in overflow mode");
    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_byte_count < r_frame_length))
        else $error("byte count reached frame length inside payload");
    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.frame_done) |=> (r_phase == PH_IDLE))
        else $error("parser did not stop after frame outcome");
`endif

endmodule

`default_nettype wire
